// ----- rtl/core/tcrf_pkg.sv -----
`default_nettype none

package tcrf_pkg;

  // Q16.16 word and its limits
  typedef logic signed [31:0] q16_t;

  localparam q16_t Q16_MAX = 32'sh7FFF_FFFF;
  localparam q16_t Q16_MIN = 32'sh8000_0000;

  // floor(2^32 / 3); the estimate it gives is at most one below the quotient
  localparam logic [31:0] RECIP3 = 32'h5555_5555;

  localparam int unsigned TYPE_W  = 2;
  localparam int unsigned CFG_W   = 3;
  localparam int unsigned NUM_STG = 12;
  localparam int unsigned IN_W    = 288;
  localparam int unsigned OUT_W   = 224;

  // register map: quadratic coefficients first, then quartic ones
  localparam int unsigned REG_QUAD_BASE  = 0;
  localparam int unsigned REG_QUART_BASE = 4;

endpackage

`default_nettype wire

// ----- rtl/core/triangle_center_restraint_force.sv -----
// Triangle center restraint force, one improper per request.
//
// Input stream (s_axis_*): tuser carries the improper type, tdata the three
// bond vectors b, c, d from the center atom to the corners (Q16.16 each).
// Output stream (m_axis_*): energy, center force and the common corner force.
// Coefficients k and chi per type are written through cfg_we_i / cfg_idx_i /
// cfg_wdata_i while no request is in flight; registers 0..3 hold k, 4..7 chi.
//
// One request may enter every cycle while the output is not stalled: the 12
// register stages each hold one multiplier level (or one add/compare/saturate
// level), so the multipliers set the pace. Each stage carries its own valid
// bit; a stage takes new data whenever it is empty or the stage after it
// moves, so a stalled receiver only backs up the pipeline as far as it is
// full and bubbles are squeezed out meanwhile. Nothing is dropped or repeated
// while m_axis_tready_i is low.
//
// Reset clears every valid bit and all coefficients to zero; the output
// stream is empty right after reset.

`default_nettype none

module triangle_center_restraint_force
  import tcrf_pkg::*;
#(
  parameter int unsigned NUM_TYPES = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  input  wire logic                cfg_we_i,
  input  wire logic [CFG_W-1:0]    cfg_idx_i,
  input  wire logic [31:0]         cfg_wdata_i,

  input  wire logic                s_axis_tvalid_i,
  output      logic                s_axis_tready_o,
  // bond_b_x, bond_b_y, bond_b_z, bond_c_x, bond_c_y, bond_c_z,
  // bond_d_x, bond_d_y, bond_d_z (32 bits each, lowest first)
  input  wire logic [IN_W-1:0]     s_axis_tdata_i,
  // type_index
  input  wire logic [TYPE_W-1:0]   s_axis_tuser_i,

  output      logic                m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // energy, centre_force_x, centre_force_y, centre_force_z,
  // corner_force_x, corner_force_y, corner_force_z (32 bits each, lowest first)
  output      logic [OUT_W-1:0]    m_axis_tdata_o
);

  // Finish a truncating divide by three: the reciprocal estimate is at most
  // one short, so one compare against the remainder fixes it.
  function automatic logic [32:0] div3_fix(input logic [32:0] mag, input logic [31:0] qe);
    logic [34:0] rem;
    rem = 35'(mag) - (35'(qe) * 35'd3);
    div3_fix = (rem >= 35'd3) ? 33'(qe) + 33'd1 : 33'(qe);
  endfunction

  function automatic q16_t sat32(input logic signed [63:0] v);
    if (v > 64'(Q16_MAX)) begin
      sat32 = Q16_MAX;
    end else if (v < 64'(Q16_MIN)) begin
      sat32 = Q16_MIN;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Coefficient registers
  // ---------------------------------------------------------------------------
  q16_t quad_q  [NUM_TYPES];
  q16_t quart_q [NUM_TYPES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NUM_TYPES; j++) begin
        quad_q[j]  <= '0;
        quart_q[j] <= '0;
      end
    end else if (cfg_we_i) begin
      for (int j = 0; j < NUM_TYPES; j++) begin
        if (cfg_idx_i == CFG_W'(REG_QUAD_BASE + j)) quad_q[j] <= cfg_wdata_i;
        if (cfg_idx_i == CFG_W'(REG_QUART_BASE + j)) quart_q[j] <= cfg_wdata_i;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage valids and the ready chain: a stage advances when it is empty or
  // when the stage after it advances.
  // ---------------------------------------------------------------------------
  logic [NUM_STG-1:0] vld_q;
  logic [NUM_STG-1:0] adv;

  always_comb begin
    adv[NUM_STG-1] = !vld_q[NUM_STG-1] || m_axis_tready_i;
    for (int i = NUM_STG - 2; i >= 0; i--) begin
      adv[i] = !vld_q[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= s_axis_tvalid_i;
      for (int i = 1; i < NUM_STG; i++) begin
        if (adv[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  assign s_axis_tready_o = adv[0];
  assign m_axis_tvalid_o = vld_q[NUM_STG-1];

  // ---------------------------------------------------------------------------
  // Stage 1: add the three bond vectors, split into sign and magnitude
  // ---------------------------------------------------------------------------
  logic [TYPE_W-1:0] ty1_q, ty2_q, ty3_q, ty4_q;
  logic              neg1_q [3];
  logic [32:0]       mag1_q [3];
  logic signed [33:0] sum1 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum1[i] = 34'($signed(s_axis_tdata_i[32*i +: 32]))
              + 34'($signed(s_axis_tdata_i[96 + 32*i +: 32]))
              + 34'($signed(s_axis_tdata_i[192 + 32*i +: 32]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      ty1_q <= s_axis_tuser_i;
      for (int i = 0; i < 3; i++) begin
        neg1_q[i] <= sum1[i][33];
        mag1_q[i] <= sum1[i][33] ? 33'(-sum1[i]) : 33'(sum1[i]);
      end
    end
  end

  // Stage 2: reciprocal multiply for the divide by three
  logic        neg2_q  [3];
  logic [32:0] mag2_q  [3];
  logic [63:0] prod2_q [3];

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      ty2_q <= ty1_q;
      for (int i = 0; i < 3; i++) begin
        neg2_q[i]  <= neg1_q[i];
        mag2_q[i]  <= mag1_q[i];
        prod2_q[i] <= 64'(mag1_q[i]) * 64'(RECIP3);
      end
    end
  end

  // Stage 3: correct the quotient and restore the sign (truncation to zero)
  q16_t        c3_q [3];
  logic [32:0] q3   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q3[i] = div3_fix(mag2_q[i], prod2_q[i][63:32]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      ty3_q <= ty2_q;
      for (int i = 0; i < 3; i++) begin
        c3_q[i] <= neg2_q[i] ? 32'(-q3[i]) : 32'(q3[i]);
      end
    end
  end

  // Stage 4: square each offset component
  q16_t        c4_q  [3];
  logic [63:0] sq4_q [3];

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      ty4_q <= ty3_q;
      for (int i = 0; i < 3; i++) begin
        c4_q[i]  <= c3_q[i];
        sq4_q[i] <= 64'(c3_q[i]) * 64'(c3_q[i]);
      end
    end
  end

  // Stage 5: s = |c|^2 in Q16.16, saturated; fetch the type's coefficients
  q16_t        c5_q [3];
  q16_t        s5_q, k5_q, chi5_q;
  logic [63:0] sq_sum5;
  logic [47:0] sq_sh5;
  q16_t        k_sel, chi_sel;

  always_comb begin
    sq_sum5 = sq4_q[0] + sq4_q[1] + sq4_q[2];
    sq_sh5  = sq_sum5[63:16];
    // types beyond the table read as zero coefficients
    k_sel   = '0;
    chi_sel = '0;
    for (int j = 0; j < NUM_TYPES; j++) begin
      if (ty4_q == TYPE_W'(j)) begin
        k_sel   = quad_q[j];
        chi_sel = quart_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      c5_q   <= c4_q;
      s5_q   <= (sq_sh5 > 48'(Q16_MAX)) ? Q16_MAX : sq_sh5[31:0];
      k5_q   <= k_sel;
      chi5_q <= chi_sel;
    end
  end

  // Stage 6: chi*s and k*s
  q16_t               c6_q [3];
  q16_t               s6_q, k6_q;
  logic signed [63:0] chis6_q, ks6_q;

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      c6_q    <= c5_q;
      s6_q    <= s5_q;
      k6_q    <= k5_q;
      chis6_q <= 64'(chi5_q) * 64'(s5_q);
      ks6_q   <= 64'(k5_q) * 64'(s5_q);
    end
  end

  // Stage 7: floor both products to Q16.16; saturate t
  q16_t               c7_q [3];
  q16_t               s7_q, k7_q, t7_q;
  logic signed [47:0] ksf7_q;
  logic signed [63:0] chis_sh7, ks_sh7;

  assign chis_sh7 = chis6_q >>> 16;
  assign ks_sh7   = ks6_q >>> 16;

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      c7_q   <= c6_q;
      s7_q   <= s6_q;
      k7_q   <= k6_q;
      t7_q   <= sat32(chis_sh7);
      ksf7_q <= ks_sh7[47:0];
    end
  end

  // Stage 8: t*s for the quartic energy term; a = 2*(k + 2t)
  q16_t               c8_q [3];
  q16_t               a8_q;
  logic signed [47:0] ksf8_q;
  logic signed [63:0] ts8_q;
  logic signed [63:0] a_wide8;

  assign a_wide8 = (64'(k7_q) + (64'(t7_q) <<< 1)) <<< 1;

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      c8_q   <= c7_q;
      ksf8_q <= ksf7_q;
      ts8_q  <= 64'(t7_q) * 64'(s7_q);
      a8_q   <= sat32(a_wide8);
    end
  end

  // Stage 9: sum the energy terms; a*c per component
  q16_t               e9_q;
  logic signed [63:0] fcp9_q [3];
  logic signed [63:0] esum9;

  assign esum9 = 64'(ksf8_q) + (ts8_q >>> 16);

  always_ff @(posedge clk_i) begin
    if (adv[8]) begin
      e9_q <= sat32(esum9);
      for (int i = 0; i < 3; i++) begin
        fcp9_q[i] <= 64'(a8_q) * 64'(c8_q[i]);
      end
    end
  end

  // Stage 10: floor and saturate the center force
  q16_t e10_q;
  q16_t fc10_q [3];

  always_ff @(posedge clk_i) begin
    if (adv[9]) begin
      e10_q <= e9_q;
      for (int i = 0; i < 3; i++) begin
        fc10_q[i] <= sat32(fcp9_q[i] >>> 16);
      end
    end
  end

  // Stage 11: reciprocal multiply for the corner force, -fc/3
  q16_t        e11_q;
  q16_t        fc11_q   [3];
  logic        pos11_q  [3];
  logic [31:0] mag11_q  [3];
  logic [63:0] prod11_q [3];
  logic [31:0] mag11    [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag11[i] = fc10_q[i][31] ? 32'(-fc10_q[i]) : 32'(fc10_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[10]) begin
      e11_q <= e10_q;
      for (int i = 0; i < 3; i++) begin
        fc11_q[i]   <= fc10_q[i];
        pos11_q[i]  <= !fc10_q[i][31];
        mag11_q[i]  <= mag11[i];
        prod11_q[i] <= 64'(mag11[i]) * 64'(RECIP3);
      end
    end
  end

  // Stage 12: correct the quotient, negate, hold for the output handshake
  q16_t        e12_q;
  q16_t        fc12_q [3];
  q16_t        cf12_q [3];
  logic [32:0] q12    [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q12[i] = div3_fix(33'(mag11_q[i]), prod11_q[i][63:32]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[11]) begin
      e12_q <= e11_q;
      for (int i = 0; i < 3; i++) begin
        fc12_q[i] <= fc11_q[i];
        cf12_q[i] <= pos11_q[i] ? 32'(-q12[i]) : 32'(q12[i]);
      end
    end
  end

  assign m_axis_tdata_o = {cf12_q[2], cf12_q[1], cf12_q[0],
                           fc12_q[2], fc12_q[1], fc12_q[0], e12_q};

endmodule

`default_nettype wire
